// ===== rtl/core/aarm_pkg.sv =====
// Package for the axis-angle rotation matrix core: widths, CORDIC constants,
// the arctangent table and a saturation helper. No dependencies.
package aarm_pkg;

  localparam int DATA_W       = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 14;
  localparam int MAX_STEPS    = 24;
  localparam int ANG_W        = 36;   // Q2.30 plus headroom for range reduction
  localparam int XY_W         = 34;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [XY_W-1:0]  ONE_Q30     = 34'sd1073741824;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF;  20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF;  default: v = 32'h0000007F;
    endcase
    return ANG_W'(signed'({1'b0, v}));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[DATA_W-1:0];
  endfunction

  typedef struct packed {
    logic signed [DATA_W-1:0] kx;
    logic signed [DATA_W-1:0] ky;
    logic signed [DATA_W-1:0] kz;
    logic                     zero;
  } axis_t;

endpackage

// ===== rtl/core/aarm_cordic.sv =====
// Unrolled, fully pipelined rotation-mode CORDIC: one step per stage.
// Depends on aarm_pkg. Carries the axis alongside as a sideband.
module aarm_cordic #(
  parameter int STEPS = aarm_pkg::CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [aarm_pkg::DATA_W-1:0] in_angle,
  input  aarm_pkg::axis_t                   in_axis,
  output logic                              out_valid,
  output logic signed [aarm_pkg::XY_W-1:0]  out_cos,
  output logic signed [aarm_pkg::XY_W-1:0]  out_sin,
  output aarm_pkg::axis_t                   out_axis
);
  import aarm_pkg::*;

  // stage 0: range reduction
  logic signed [ANG_W-1:0] z0_r;
  logic                    neg0_r, v0_r;
  axis_t                   ax0_r;
  logic signed [ANG_W-1:0] za, zb, zc, zd, ze, z0_nxt;
  logic                    neg0_nxt;

  always_comb begin
    za = ANG_W'(in_angle) <<< 18;
    zb = (za > PI_Q30) ? za - TWO_PI_Q30 : za;
    zc = (zb > PI_Q30) ? zb - TWO_PI_Q30 : zb;
    zd = (zc <= -PI_Q30) ? zc + TWO_PI_Q30 : zc;
    ze = (zd <= -PI_Q30) ? zd + TWO_PI_Q30 : zd;
    neg0_nxt = 1'b1;
    if (ze > HALF_PI_Q30) z0_nxt = ze - PI_Q30;
    else if (ze < -HALF_PI_Q30) z0_nxt = ze + PI_Q30;
    else begin
      z0_nxt = ze;
      neg0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
    if (en) begin
      z0_r <= z0_nxt;
      neg0_r <= neg0_nxt;
      ax0_r <= in_axis;
    end
  end

  logic signed [XY_W-1:0]  x_r [STEPS+1];
  logic signed [XY_W-1:0]  y_r [STEPS+1];
  logic signed [ANG_W-1:0] z_r [STEPS+1];
  logic                    n_r [STEPS+1];
  logic                    v_r [STEPS+1];
  axis_t                   a_r [STEPS+1];

  always_comb begin
    x_r[0] = GAIN_Q30;
    y_r[0] = '0;
    z_r[0] = z0_r;
    n_r[0] = neg0_r;
    v_r[0] = v0_r;
    a_r[0] = ax0_r;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XY_W-1:0]  x_nxt, y_nxt;
    logic signed [ANG_W-1:0] z_nxt;
    always_comb begin
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan_q30(i);
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= v_r[i];
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        n_r[i+1] <= n_r[i];
        a_r[i+1] <= a_r[i];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_cos   = n_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign out_sin   = n_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  assign out_axis  = a_r[STEPS];
endmodule

// ===== rtl/core/aarm_matrix.sv =====
// Rodrigues entry pipeline: products, rounding, sums and saturation.
// Depends on aarm_pkg. Three register stages.
module aarm_matrix #(
  parameter int FRAC = aarm_pkg::FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [aarm_pkg::XY_W-1:0]   in_cos,
  input  logic signed [aarm_pkg::XY_W-1:0]   in_sin,
  input  aarm_pkg::axis_t                    in_axis,
  output logic                               out_valid,
  output logic signed [aarm_pkg::DATA_W-1:0] out_cell [9]
);
  import aarm_pkg::*;

  localparam logic signed [63:0] HALF_F  = 64'sd1 <<< (FRAC - 1);
  localparam logic signed [63:0] HALF_30 = 64'sd1 <<< 29;
  localparam logic signed [63:0] ONE_F   = 64'sd1 <<< FRAC;

  // stage 1: axis pair products, 1-c, and k*s
  logic signed [31:0] kk_r [9];
  logic signed [63:0] ks_r [3];
  logic signed [XY_W:0] omc_r;
  logic signed [XY_W-1:0] c1_r;
  logic v1_r, z1_r;

  // stage 2: rounded product terms
  logic signed [63:0] t_r [9];
  logic signed [63:0] ks2_r [3];
  logic signed [XY_W-1:0] c2_r;
  logic v2_r, z2_r;

  logic signed [DATA_W-1:0] k [3];
  assign k[0] = in_axis.kx;
  assign k[1] = in_axis.ky;
  assign k[2] = in_axis.kz;

  // stage 3: combine and saturate
  function automatic logic signed [DATA_W-1:0] cell_val(input int e);
    logic signed [63:0] sum;
    logic signed [63:0] base;
    base = 64'(c2_r) <<< FRAC;
    case (e)
      0, 4, 8: sum = t_r[e] + base;
      1: sum = t_r[1] - ks2_r[2];
      2: sum = t_r[2] + ks2_r[1];
      3: sum = t_r[3] + ks2_r[2];
      5: sum = t_r[5] - ks2_r[0];
      6: sum = t_r[6] - ks2_r[1];
      default: sum = t_r[7] + ks2_r[0];
    endcase
    if (z2_r) return (e == 0 || e == 4 || e == 8) ? sat16(ONE_F) : '0;
    return sat16((sum + HALF_30) >>> 30);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      out_valid <= v2_r;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) kk_r[3*a+b] <= 32'(k[a]) * 32'(k[b]);
        ks_r[a] <= 64'(k[a]) * 64'(in_sin);
      end
      omc_r <= (XY_W+1)'(ONE_Q30) - (XY_W+1)'(in_cos);
      c1_r <= in_cos;
      z1_r <= in_axis.zero;
      for (int e = 0; e < 9; e++)
        t_r[e] <= (64'(kk_r[e]) * 64'(omc_r) + HALF_F) >>> FRAC;
      ks2_r <= ks_r;
      c2_r <= c1_r;
      z2_r <= z1_r;
      for (int e = 0; e < 9; e++) out_cell[e] <= cell_val(e);
    end
  end
endmodule

// ===== rtl/core/axis_angle_rotation_matrix_core.sv =====
// Top level of the axis-angle rotation matrix core (Rodrigues' formula).
// Depends on aarm_pkg, aarm_cordic and aarm_matrix.
//
// channel | dir | fields (low bit first)
// in_*    | in  | tdata: axis_x, axis_y, axis_z, angle (16 each)
// out_*   | out | tdata: cell_0_0 .. cell_2_2 (16 each, 144 bits)
//
// One item per cycle while the output is not stalled. Stages: one range
// reduction stage, one stage per CORDIC step, three matrix stages.
// The whole pipeline advances only when the output register is free or
// being drained, so a stall holds every stage and nothing is lost.
// rst_n clears the valid bits only.
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS,
  parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // axis_x, axis_y, axis_z, angle
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata   // cell_0_0 .. cell_2_2
);
  import aarm_pkg::*;

  logic en;
  axis_t ax_in, ax_c;
  logic cv;
  logic signed [XY_W-1:0] cs, sn;
  logic signed [DATA_W-1:0] mat [9];

  // pipeline advances when the final register is empty or being taken
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    ax_in.kx = in_tdata[15:0];
    ax_in.ky = in_tdata[31:16];
    ax_in.kz = in_tdata[47:32];
    ax_in.zero = (in_tdata[47:0] == '0);
  end

  aarm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .en,
    .in_valid(in_tvalid), .in_angle(in_tdata[63:48]), .in_axis(ax_in),
    .out_valid(cv), .out_cos(cs), .out_sin(sn), .out_axis(ax_c)
  );

  aarm_matrix #(.FRAC(FRAC_BITS)) u_matrix (
    .clk, .rst_n, .en,
    .in_valid(cv), .in_cos(cs), .in_sin(sn), .in_axis(ax_c),
    .out_valid(out_tvalid), .out_cell(mat)
  );

  for (genvar e = 0; e < 9; e++) begin : g_pack
    assign out_tdata[16*e +: 16] = mat[e];
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline stalled with empty output");
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");
`endif
endmodule

// ===== verif/tb.sv =====
// Testbench for axis_angle_rotation_matrix_core: directed table plus random
// axis/angle items checked against a bit-exact Rodrigues/CORDIC predictor.
// Depends on aarm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import aarm_pkg::*;

  localparam int STEPS = aarm_pkg::CORDIC_STEPS;
  localparam int FB    = aarm_pkg::FRAC_BITS;
  localparam int LAT   = STEPS + 4;

  typedef logic signed [63:0] s64_t;

  typedef struct {
    logic signed [15:0] kx, ky, kz, ang;
    bit                 has_exp;
    logic [143:0]       exp;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  logic [143:0] matrix_q[$];
  int           errors = 0;
  int           snd_idle = 12, rcv_idle = 57;

  axis_angle_rotation_matrix_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic s64_t floor_shr(s64_t v, int s);
    return v >>> s;
  endfunction

  function automatic s64_t rnd_shr(s64_t v, int s);
    if (s == 0) return v;
    return (v + (s64_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] clip16(s64_t v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // one entry: c*(ka==kb diag) + ka*kb*(1-c) + sg*kd*s
  function automatic logic [15:0] entry_val(s64_t c, s64_t omc, s64_t s, s64_t ka,
                                            s64_t kb, s64_t kd, int sg);
    s64_t t, u, sum;
    t = rnd_shr(ka * kb * omc, FB);
    u = kd * s;
    sum = t + (sg > 0 ? u : (sg < 0 ? -u : s64_t'(0)));
    if (sg == 0) sum += c * (s64_t'(1) <<< FB);
    return clip16(rnd_shr(sum, 30));
  endfunction

  function automatic logic [143:0] rotation_matrix(logic signed [15:0] kx16,
      logic signed [15:0] ky16, logic signed [15:0] kz16, logic signed [15:0] a16);
    s64_t kx, ky, kz, z, x, y, nx, c, s, omc, at;
    bit flip;
    logic [143:0] m;
    kx = kx16; ky = ky16; kz = kz16;
    if (kx == 0 && ky == 0 && kz == 0) begin
      m = '0;
      m[15:0] = clip16(s64_t'(1) <<< FB);
      m[79:64] = m[15:0];
      m[143:128] = m[15:0];
      return m;
    end
    z = s64_t'(a16) <<< 18;
    flip = 0;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    if (z <= -PI_Q30) z += TWO_PI_Q30;
    if (z <= -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30; flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30; flip = 1;
    end
    x = GAIN_Q30; y = 0;
    for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
      at = atan_q30(i);
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= at;
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += at;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = ONE_Q30 - c;
    m[15:0]    = entry_val(c, omc, s, kx, kx, 0, 0);
    m[31:16]   = entry_val(c, omc, s, kx, ky, kz, -1);
    m[47:32]   = entry_val(c, omc, s, kx, kz, ky, 1);
    m[63:48]   = entry_val(c, omc, s, ky, kx, kz, 1);
    m[79:64]   = entry_val(c, omc, s, ky, ky, 0, 0);
    m[95:80]   = entry_val(c, omc, s, ky, kz, kx, -1);
    m[111:96]  = entry_val(c, omc, s, kz, kx, ky, -1);
    m[127:112] = entry_val(c, omc, s, kz, ky, kx, 1);
    m[143:128] = entry_val(c, omc, s, kz, kz, 0, 0);
    return m;
  endfunction

  // send one item; expectation queued at acceptance
  task automatic send_axis_angle(logic signed [15:0] kx, logic signed [15:0] ky,
      logic signed [15:0] kz, logic signed [15:0] ang, bit typed, logic [143:0] tv);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ang, kz, ky, kx};
    do @(posedge clk); while (!in_tready);
    matrix_q.push_back(typed ? tv : rotation_matrix(kx, ky, kz, ang));
  endtask

  // receiver: random stalls, checks at accepted handshakes
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        logic [143:0] e;
        e = matrix_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (e[16*k +: 16] !== out_tdata[16*k +: 16]) begin
            $display("%0t cell %0d_%0d expected %h actual %h", $time, k / 3, k % 3,
                     e[16*k +: 16], out_tdata[16*k +: 16]);
            errors++;
          end
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    row_t dir[$];
    row_t r;
    logic [143:0] ident;
    logic signed [15:0] v[4];
    int phase_len;
    ident = '0;
    ident[15:0] = 16'h4000; ident[79:64] = 16'h4000; ident[143:128] = 16'h4000;
    // zero axis gives the identity whatever the angle
    r = '{0, 0, 0, 16'sh7FFF, 1, ident}; dir.push_back(r);
    r = '{0, 0, 0, -16'sh8000, 1, ident}; dir.push_back(r);
    r = '{0, 0, 0, 0, 1, ident}; dir.push_back(r);
    // unit x axis, zero angle
    r = '{16'sh4000, 0, 0, 0, 0, '0}; dir.push_back(r);
    // extremes, non-unit axes and saturation
    r = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, '0}; dir.push_back(r);
    r = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0, '0}; dir.push_back(r);
    r = '{-16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh1922, 0, '0}; dir.push_back(r);
    r = '{0, 16'sh4000, 0, 16'sh1922, 0, '0}; dir.push_back(r);   // ~pi/2
    r = '{0, 0, 16'sh4000, 16'sh3244, 0, '0}; dir.push_back(r);   // ~pi
    r = '{0, 0, 16'sh4000, -16'sh3244, 0, '0}; dir.push_back(r);
    r = '{16'sh24F3, 16'sh24F3, 16'sh24F3, 16'sh2183, 0, '0}; dir.push_back(r);
    r = '{16'sh0001, 0, 0, 16'sh6488, 0, '0}; dir.push_back(r);   // ~2pi
    r = '{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 0, '0}; dir.push_back(r);
    r = '{16'sh5555, -16'sh2AAB, 16'sh1234, 16'sh5000, 0, '0}; dir.push_back(r);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i])
      send_axis_angle(dir[i].kx, dir[i].ky, dir[i].kz, dir[i].ang,
                      dir[i].has_exp, dir[i].exp);

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        snd_idle = 57; rcv_idle = 12;
      end else if (p == 2) begin
        snd_idle = 0; rcv_idle = 0;
      end
      phase_len = 262;
      for (int n = 0; n < phase_len; n++) begin
        for (int f = 0; f < 4; f++)
          case ($urandom_range(9))
            0: v[f] = 16'sh7FFF;
            1: v[f] = -16'sh8000;
            2: v[f] = 0;
            3, 4: v[f] = 16'($urandom_range(16'h4000) - 16'h2000);  // near unit range
            default: v[f] = 16'($urandom);
          endcase
        if ($urandom_range(9) == 0) begin
          v[0] = 0; v[1] = 0; v[2] = 0;
        end
        send_axis_angle(v[0], v[1], v[2], v[3], 0, '0);
      end
    end
    in_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
